[rtl/fliq_pkg.sv]
// ----------------------------------------------------------------------------
// fliq_pkg
// Shared types and constants for the float linear quantizer.
// ----------------------------------------------------------------------------
package fliq_pkg;

    // Field widths
    localparam int SAMPLE_W = 32;
    localparam int CODE_W   = 25;
    localparam int KEPT_W   = 5;
    localparam int OFFSET_W = 25;
    localparam int EXP_W    = 9;
    localparam int CFG_W    = 25;
    localparam int INDEX_W  = 2;

    // Significand with hidden bit, and working widths of the datapath
    localparam int SIG_BITS = 24;
    localparam int MAG_W    = 51;
    localparam int SUM_W    = 53;
    localparam int SHIFT_W  = 11;

    // Default for the largest number of kept bits
    localparam int MAX_KEPT_BITS_DEF = 24;

    // Saturated code value
    localparam logic [CODE_W-1:0] CODE_MAX = {CODE_W{1'b1}};

    // Register indexes
    localparam logic [INDEX_W-1:0] REG_KEPT_BITS    = 2'd0;
    localparam logic [INDEX_W-1:0] REG_MIN_OFFSET   = 2'd1;
    localparam logic [INDEX_W-1:0] REG_MAX_EXPONENT = 2'd2;

    // Reset values
    localparam logic [KEPT_W-1:0]   KEPT_BITS_RST    = 5'd16;
    localparam logic [OFFSET_W-1:0] MIN_OFFSET_RST   = '0;
    localparam logic [EXP_W-1:0]    MAX_EXPONENT_RST = '0;

    // Configuration as seen by the datapath (offset and exponent are two's complement)
    typedef struct packed {
        logic [KEPT_W-1:0]   kept_bits;
        logic [OFFSET_W-1:0] min_offset;
        logic [EXP_W-1:0]    max_exponent;
    } cfg_t;

endpackage

[rtl/fliq_cfg_regs.sv]
// ----------------------------------------------------------------------------
// fliq_cfg_regs
// Configuration register file: kept bits, minimum offset, maximum exponent.
// ----------------------------------------------------------------------------
module fliq_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [fliq_pkg::INDEX_W-1:0] cfg_index,
    input  logic [fliq_pkg::CFG_W-1:0]   cfg_data,
    output fliq_pkg::cfg_t               cfg
);

    fliq_pkg::cfg_t cfg_reg;
    fliq_pkg::cfg_t cfg_next;

    // Register decode; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                fliq_pkg::REG_KEPT_BITS:
                    cfg_next.kept_bits = cfg_data[fliq_pkg::KEPT_W-1:0];
                fliq_pkg::REG_MIN_OFFSET:
                    cfg_next.min_offset = cfg_data[fliq_pkg::OFFSET_W-1:0];
                fliq_pkg::REG_MAX_EXPONENT:
                    cfg_next.max_exponent = cfg_data[fliq_pkg::EXP_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kept_bits    <= fliq_pkg::KEPT_BITS_RST;
            cfg_reg.min_offset   <= fliq_pkg::MIN_OFFSET_RST;
            cfg_reg.max_exponent <= fliq_pkg::MAX_EXPONENT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/fliq_quant.sv]
// ----------------------------------------------------------------------------
// fliq_quant
// Combinational quantizer: scale, truncate, offset, round, shift and clamp.
// ----------------------------------------------------------------------------
module fliq_quant #(
    parameter int MAX_KEPT_BITS = fliq_pkg::MAX_KEPT_BITS_DEF
) (
    input  logic [fliq_pkg::SAMPLE_W-1:0] sample_bits,
    input  fliq_pkg::cfg_t                cfg,
    output logic [fliq_pkg::CODE_W-1:0]   code,
    output logic                          saturated
);

    localparam int SW = fliq_pkg::SHIFT_W;
    localparam int MW = fliq_pkg::MAG_W;
    localparam int UW = fliq_pkg::SUM_W;
    localparam int GW = fliq_pkg::SIG_BITS;

    logic                 neg;
    logic [7:0]           exp_field;
    logic [22:0]          frac;
    logic [GW-1:0]        mant;
    logic signed [SW-1:0] exp_unb;
    logic signed [SW-1:0] shift;
    logic signed [SW-1:0] neg_shift;
    logic [MW-1:0]        mag;
    logic signed [UW-1:0] term;
    logic [4:0]           kept_eff;
    logic [4:0]           rshift;
    logic [GW-1:0]        rnd;
    logic signed [UW-1:0] sum;
    logic [UW-1:0]        quot;

    // Unpack the sample; denormals use exponent -126 without the hidden bit
    always_comb
    begin
        neg       = sample_bits[31];
        exp_field = sample_bits[30:23];
        frac      = sample_bits[22:0];
        mant      = {(exp_field != 8'd0), frac};
        if (exp_field == 8'd0)
            exp_unb = -11'sd126;
        else
            exp_unb = $signed({3'b000, exp_field}) - 11'sd127;
        shift = exp_unb - $signed({{(SW-fliq_pkg::EXP_W){cfg.max_exponent[8]}},
                                   cfg.max_exponent});
        neg_shift = -shift;
    end

    // Exact scaling by 2^shift, truncated; large shifts are capped at 2^50
    always_comb
    begin
        if (mant == '0)
            mag = '0;
        else if (shift >= 11'sd27)
            mag = {1'b1, {(MW-1){1'b0}}};
        else if (shift >= 11'sd0)
            mag = {{(MW-GW){1'b0}}, mant} << shift[4:0];
        else if (shift <= -11'sd32)
            mag = '0;
        else
            mag = {{(MW-GW){1'b0}}, mant} >> neg_shift[4:0];
        if (neg)
            term = -$signed({2'b00, mag});
        else
            term = $signed({2'b00, mag});
    end

    // Kept-bit clamp, rounding term and output shift
    always_comb
    begin
        if (cfg.kept_bits == 5'd0)
            kept_eff = 5'd1;
        else if (cfg.kept_bits > 5'(MAX_KEPT_BITS))
            kept_eff = 5'(MAX_KEPT_BITS);
        else
            kept_eff = cfg.kept_bits;
        rshift = 5'(GW) - kept_eff;
        if (kept_eff < 5'(GW))
            rnd = GW'(1) << (5'(GW - 1) - kept_eff);
        else
            rnd = '0;
    end

    // Offset, shift and clamp
    always_comb
    begin
        sum = term + $signed({{(UW-GW){1'b0}}, rnd})
                   - $signed({{(UW-fliq_pkg::OFFSET_W){cfg.min_offset[24]}},
                              cfg.min_offset});
        quot = sum >> rshift;
        if (exp_field == 8'hFF)
        begin
            code      = fliq_pkg::CODE_MAX;
            saturated = 1'b1;
        end
        else if (sum[UW-1])
        begin
            code      = '0;
            saturated = 1'b0;
        end
        else if (|quot[UW-1:fliq_pkg::CODE_W])
        begin
            code      = fliq_pkg::CODE_MAX;
            saturated = 1'b1;
        end
        else
        begin
            code      = quot[fliq_pkg::CODE_W-1:0];
            saturated = 1'b0;
        end
    end

endmodule

[rtl/float_linear_quantizer_core.sv]
// ----------------------------------------------------------------------------
// float_linear_quantizer_core
// Quantizes single-precision samples to offset, rounded, clamped codes.
// ----------------------------------------------------------------------------
//  channel   signals                          direction  moves
//  input     in_valid/in_ready, sample_bits   in         one sample request
//  output    out_valid/out_ready, code,       out        one code request
//            saturated
//  config    cfg_write, cfg_index, cfg_data   in         register write
//
//  One sample per cycle sustained unless the output stalls. A sample goes
//  from the sample register through the quantizer into the result
//  register, where out_valid rises with its code.
//  A stalled output holds its result; the sample register keeps taking a new
//  request while it can move its item forward into the result register.
//  Reset clears both valid flags and loads the register reset values.
// ----------------------------------------------------------------------------
module float_linear_quantizer_core #(
    parameter int MAX_KEPT_BITS = fliq_pkg::MAX_KEPT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [fliq_pkg::SAMPLE_W-1:0] sample_bits,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [fliq_pkg::CODE_W-1:0]   code,
    output logic                          saturated,
    input  logic                          cfg_write,
    input  logic [fliq_pkg::INDEX_W-1:0]  cfg_index,
    input  logic [fliq_pkg::CFG_W-1:0]    cfg_data
);

    fliq_pkg::cfg_t cfg;

    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic [fliq_pkg::SAMPLE_W-1:0] s1_sample_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [fliq_pkg::CODE_W-1:0]   code_reg;
    logic                          sat_reg;
    logic [fliq_pkg::CODE_W-1:0]   q_code;
    logic                          q_sat;
    logic                          out_adv;
    logic                          s1_adv;
    logic                          in_take;

    // Configuration registers
    fliq_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Quantizer between sample and result registers
    fliq_quant #(
        .MAX_KEPT_BITS (MAX_KEPT_BITS)
    ) u_quant (
        .sample_bits (s1_sample_reg),
        .cfg         (cfg),
        .code        (q_code),
        .saturated   (q_sat)
    );

    // Pipeline flow control
    always_comb
    begin
        out_adv        = !out_valid_reg || out_ready;
        s1_adv         = s1_valid_reg && out_adv;
        in_ready       = !s1_valid_reg || out_adv;
        in_take        = in_valid && in_ready;
        s1_valid_next  = in_take || (s1_valid_reg && !s1_adv);
        out_valid_next = s1_adv || (out_valid_reg && !out_ready);
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_sample_reg <= sample_bits;
        if (s1_adv)
        begin
            code_reg <= q_code;
            sat_reg  <= q_sat;
        end
    end

    assign out_valid = out_valid_reg;
    assign code      = code_reg;
    assign saturated = sat_reg;

`ifndef SYNTHESIS
    // Input stalls only when both stages are full and the output is blocked
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg && !out_ready))
        else $error("in_ready low with room in the pipeline");

    // A held sample keeps its slot and its data
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_adv) |=> (s1_valid_reg && $stable(s1_sample_reg)))
        else $error("sample register lost or changed a stalled item");

    // Inf and NaN samples reach the output saturated
    a_special_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && (s1_sample_reg[30:23] == 8'hFF)) |=>
            (out_valid_reg && sat_reg && (code_reg == fliq_pkg::CODE_MAX)))
        else $error("inf or NaN not saturated");

    // Saturation flag always comes with the full-scale code
    a_sat_code: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && sat_reg) |-> (code_reg == fliq_pkg::CODE_MAX))
        else $error("saturated result without full-scale code");
`endif

endmodule
